// ===== rtl/core/mtf_pkg.sv =====
`default_nettype none

package mtf_pkg;

    // list geometry
    localparam int MAX_ENTRIES = 16;
    localparam int KEY_BITS    = 32;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CAP_W       = 5;
    localparam int SAT_W       = (CAP_W > CNT_W) ? CAP_W : CNT_W;

    // capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // item operation codes
    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_DUMP   = 1'b1;

    typedef struct packed {
        logic                opcode;
        logic [KEY_BITS-1:0] key;
    } t_in_item;

    typedef struct packed {
        logic [KEY_BITS-1:0] entry_key;
        logic                is_empty;
        logic                last;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic access;
        logic dump_start;
        logic emit;
    } t_mtf_cmd;

    // datapath to controller
    typedef struct packed {
        logic dump_last;
    } t_mtf_status;

endpackage

`default_nettype wire

// ===== rtl/core/mtf_ctrl.sv =====
`default_nettype none

module mtf_ctrl (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_start,
    input  wire                       i_opcode,
    input  wire mtf_pkg::t_mtf_status i_status,
    output mtf_pkg::t_mtf_cmd         o_cmd,
    output logic                      o_busy
);
    import mtf_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ACC  = 2'd1;
    localparam logic [1:0] ST_DUMP = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_opcode == OP_ACCESS) begin
                        n_state = ST_ACC;
                    end else begin
                        o_cmd.dump_start = 1'b1;
                        n_state          = ST_DUMP;
                    end
                end
            end
            ST_ACC: begin
                o_cmd.access = 1'b1;
                n_state      = ST_IDLE;
            end
            ST_DUMP: begin
                o_cmd.emit = 1'b1;
                if (i_status.dump_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

`default_nettype wire

// ===== rtl/core/mtf_datapath.sv =====
`default_nettype none

module mtf_datapath (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire mtf_pkg::t_mtf_cmd       i_cmd,
    input  wire [mtf_pkg::KEY_BITS-1:0]  i_key,
    input  wire                          i_cfg_we,
    input  wire [mtf_pkg::CAP_W-1:0]     i_cfg_data,
    output mtf_pkg::t_mtf_status         o_status,
    output logic                         o_strobe,
    output mtf_pkg::t_out_item           o_item
);
    import mtf_pkg::*;

    // saturate capacity to 1..MAX_ENTRIES
    function automatic logic [CNT_W-1:0] cap_sat(input logic [CAP_W-1:0] cap);
        logic [SAT_W-1:0] wide;
        logic [CNT_W-1:0] res;
        wide = SAT_W'(cap);
        if (cap == '0) begin
            res = CNT_W'(1);
        end else if (wide > SAT_W'(MAX_ENTRIES)) begin
            res = CNT_W'(MAX_ENTRIES);
        end else begin
            res = CNT_W'(wide);
        end
        return res;
    endfunction

    logic [KEY_BITS-1:0]  r_keys [MAX_ENTRIES];
    logic [KEY_BITS-1:0]  r_key;
    logic [CNT_W-1:0]     r_count;
    logic [CAP_W-1:0]     r_cap;
    logic [IDX_W-1:0]     r_idx;
    logic                 r_strobe;
    t_out_item            r_item;

    logic [MAX_ENTRIES-1:0] hit;
    logic [MAX_ENTRIES-1:0] hit_below;
    logic [CNT_W-1:0]       cap_use;
    logic [CNT_W-1:0]       cap_new;
    logic                   dump_last;

    assign cap_use = cap_sat(r_cap);
    assign cap_new = cap_sat(i_cfg_data);

    // parallel key compare over the listed entries
    always_comb begin
        for (int j = 0; j < MAX_ENTRIES; j++) begin
            hit[j] = (CNT_W'(j) < r_count) && (r_keys[j] == r_key);
        end
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            hit_below[i] = |(hit & ({MAX_ENTRIES{1'b1}} >> (MAX_ENTRIES - i)));
        end
    end

    // final item of a dump run, or the single empty item
    assign dump_last = (r_count == '0) || ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);

    // key store: front takes the key, entries ahead of its old place (all on a miss) move back one place
    always_ff @(posedge i_clk) begin
        if (i_cmd.access) begin
            r_keys[0] <= r_key;
            for (int i = 1; i < MAX_ENTRIES; i++) begin
                if (!hit_below[i]) begin
                    r_keys[i] <= r_keys[i-1];
                end
            end
        end
    end

    // latched item key
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= i_key;
        end
    end

    // capacity and entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CAP_RESET;
            r_count <= '0;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_data;
            if (r_count > cap_new) begin
                r_count <= cap_new;
            end
        end else if (i_cmd.access) begin
            if ((hit == '0) && (r_count < cap_use)) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    // dump index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.dump_start) begin
            r_idx <= '0;
        end else if (i_cmd.emit) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_item.entry_key <= (r_count == '0) ? '0 : r_keys[r_idx];
            r_item.is_empty  <= (r_count == '0);
            r_item.last      <= dump_last;
        end
    end

    assign o_status.dump_last = dump_last;
    assign o_strobe           = r_strobe;
    assign o_item             = r_item;

endmodule

`default_nettype wire

// ===== rtl/core/move_to_front_recent_list_top.sv =====
`default_nettype none

// Move-to-front recent list. Pulse i_start with an item while o_busy is low.
// An access is accepted, then in ST_ACC all 16 entries are compared with
// the key and shifted at once; it gives no result. A dump keeps the block
// busy until the last entry, or the single empty item, is emitted, and
// streams one result per cycle on o_strobe, through the state and result
// registers after acceptance; the final one carries last. Results are shown
// for exactly one cycle and cannot be held off by the receiver. Capacity is
// written through i_cfg_we/i_cfg_data, by the user, while the block is idle;
// the block does not enforce it. Lowering capacity trims the list at once.
module move_to_front_recent_list_top (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_start,
    output logic                      o_busy,
    input  wire mtf_pkg::t_in_item    i_item,
    output logic                      o_strobe,
    output mtf_pkg::t_out_item        o_item,
    input  wire                       i_cfg_we,
    input  wire [mtf_pkg::CAP_W-1:0]  i_cfg_data
);
    import mtf_pkg::*;

    t_mtf_cmd    cmd;
    t_mtf_status status;

    // sequencer
    mtf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_opcode (i_item.opcode),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_busy)
    );

    // list storage, compare and result register
    mtf_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_key      (i_item.key),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_status   (status),
        .o_strobe   (o_strobe),
        .o_item     (o_item)
    );

endmodule

`default_nettype wire
